// ===== rtl/bpa_pkg.sv =====
package bpa_pkg;

   localparam int CNT_W     = 13;
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 2;
   localparam int ADDR_W    = 32;
   localparam int PADDR_W   = 24;
   localparam int CSR_IDX_W = 1;

   localparam logic [CNT_W-1:0] PAGE_COUNT_RESET     = 13'd4096;
   localparam logic [CNT_W-1:0] RESERVED_PAGES_RESET = 13'd0;

   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_COUNT     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED_PAGES = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NO_FREE = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd2;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_INIT  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_SCAN,
      ST_DIV,
      ST_REM,
      ST_CHECK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PADDR_W-1:0]  page_address;
      logic [CNT_W-1:0]    free_count;
      logic [CNT_W-1:0]    used_count;
   } result_type;

endpackage

// ===== rtl/bpa_if.sv =====
interface bpa_req_if;
   logic                          valid;
   logic                          ready;
   logic [bpa_pkg::OP_W-1:0]      op;
   logic [bpa_pkg::ADDR_W-1:0]    free_address;

   modport source (output valid, output op, output free_address, input ready);
   modport sink (input valid, input op, input free_address, output ready);
endinterface

interface bpa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bpa_pkg::STATUS_W-1:0]  status;
   logic [bpa_pkg::PADDR_W-1:0]   page_address;
   logic [bpa_pkg::CNT_W-1:0]     free_count;
   logic [bpa_pkg::CNT_W-1:0]     used_count;

   modport source (output valid, output status, output page_address, output free_count,
                   output used_count, input ready);
   modport sink (input valid, input status, input page_address, input free_count,
                 input used_count, output ready);
endinterface

interface bpa_csr_if;
   logic                          valid;
   logic                          ready;
   logic [bpa_pkg::CSR_IDX_W-1:0] index;
   logic [bpa_pkg::CNT_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/bpa_map_ram.sv =====
module bpa_map_ram #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bpa_ctrl.sv =====
module bpa_ctrl #(
   parameter int MAX_PAGES     = 4096,
   parameter int PAGE_SHIFT    = 12,
   parameter int MAP_WORD_BITS = 32,
   localparam int MAP_WORDS = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS,
   localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid_i,
   output logic                           req_ready_o,
   input  logic [bpa_pkg::OP_W-1:0]       req_op_i,
   input  logic [bpa_pkg::ADDR_W-1:0]     req_addr_i,
   input  logic [bpa_pkg::CNT_W-1:0]      pages_i,
   input  logic [bpa_pkg::CNT_W-1:0]      reserved_i,
   input  logic                           slot_free_i,
   output logic                           done_o,
   output bpa_pkg::result_type            result_o,
   output logic                           rd_en_o,
   output logic [WORD_W-1:0]              rd_addr_o,
   input  logic [MAP_WORD_BITS-1:0]       rd_data_i,
   output logic                           wr_en_o,
   output logic [WORD_W-1:0]              wr_addr_o,
   output logic [MAP_WORD_BITS-1:0]       wr_data_o
);

   import bpa_pkg::*;

   localparam int BIT_W       = $clog2(MAP_WORD_BITS);
   localparam int BASE_W      = $clog2(MAP_WORDS * MAP_WORD_BITS + MAP_WORD_BITS + 1);
   localparam int CMP_W       = ((BASE_W > CNT_W) ? BASE_W : CNT_W) + 1;
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP       = (1 << RECIP_SHIFT) / MAP_WORD_BITS;
   localparam int RECIP_W     = $clog2(RECIP + 1);
   localparam int PROD_W      = CNT_W + RECIP_W;

   state_type               state_ff, state_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic [PADDR_W-1:0]      paddr_ff, paddr_in;
   logic [CNT_W-1:0]        page_ff, page_in;
   logic [CNT_W-1:0]        used_ff, used_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic [CNT_W-1:0]        quot_ff, quot_in;
   logic [WORD_W-1:0]       word_ff, word_in;
   logic [BASE_W-1:0]       base_ff, base_in;
   logic [BIT_W-1:0]        bit_ff, bit_in;
   logic                    chk_vld_ff, chk_vld_in;
   logic [WORD_W-1:0]       chk_word_ff, chk_word_in;
   logic [BASE_W-1:0]       chk_base_ff, chk_base_in;
   logic                    respond_ff, respond_in;

   logic                    accept;
   op_type                  req_op;
   logic [ADDR_W-1:0]       free_page_idx;
   logic                    free_in_range;
   logic [CNT_W-1:0]        init_fill;
   logic                    issue;
   logic [MAP_WORD_BITS-1:0] avail;
   logic                    found;
   logic [BIT_W-1:0]        found_pos;
   logic [CMP_W-1:0]        found_page;
   logic                    scan_end;
   logic [MAP_WORD_BITS-1:0] sweep_data;
   logic                    sweep_last;
   logic [PROD_W-1:0]       recip_prod;
   logic [CMP_W-1:0]        quot_back;
   logic [CMP_W-1:0]        rem_raw;
   logic                    rem_over;
   logic [CNT_W-1:0]        fix_word;
   logic [CMP_W-1:0]        fix_bit;
   logic                    chk_hit;

   function automatic logic [CMP_W-1:0] sat_sub(input logic [CMP_W-1:0] a,
                                                input logic [CMP_W-1:0] b);
      return (a > b) ? (a - b) : '0;
   endfunction

   function automatic logic [MAP_WORD_BITS-1:0] low_ones(input logic [CMP_W-1:0] lim);
      logic [MAP_WORD_BITS-1:0] r;
      r = '0;
      for (int j = 0; j < MAP_WORD_BITS; j++) begin
         r[j] = CMP_W'(j) < lim;
      end
      return r;
   endfunction

   function automatic logic [BIT_W-1:0] first_one(input logic [MAP_WORD_BITS-1:0] v);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int j = MAP_WORD_BITS - 1; j >= 0; j--) begin
         if (v[j]) begin
            pos = BIT_W'(j);
         end
      end
      return pos;
   endfunction

   function automatic logic [PADDR_W-1:0] to_paddr(input logic [CNT_W-1:0] page);
      logic [ADDR_W-1:0] wide;
      wide = ADDR_W'(page) << PAGE_SHIFT;
      return wide[PADDR_W-1:0];
   endfunction

   // shared decode
   assign req_op        = op_type'(req_op_i);
   assign accept        = req_valid_i && (state_ff == ST_IDLE);
   assign free_page_idx = req_addr_i >> PAGE_SHIFT;
   assign free_in_range = free_page_idx < ADDR_W'(pages_i);
   assign init_fill     = (reserved_i < pages_i) ? reserved_i : pages_i;

   // first-fit scan
   assign issue      = (state_ff == ST_SCAN) && (CMP_W'(base_ff) < CMP_W'(pages_i));
   assign avail      = ~rd_data_i & low_ones(sat_sub(CMP_W'(pages_i), CMP_W'(chk_base_ff)));
   assign found      = (state_ff == ST_SCAN) && chk_vld_ff && (|avail);
   assign found_pos  = first_one(avail);
   assign found_page = CMP_W'(chk_base_ff) + CMP_W'(found_pos);
   assign scan_end   = (state_ff == ST_SCAN) && !found && !issue && !chk_vld_ff;

   // init and clearing sweep
   assign sweep_data = low_ones(sat_sub(CMP_W'(fill_ff), CMP_W'(base_ff)));
   assign sweep_last = word_ff == WORD_W'(MAP_WORDS - 1);

   // page to word and bit by reciprocal multiply with one correction
   assign recip_prod = PROD_W'(page_ff) * PROD_W'(RECIP);
   assign quot_back  = CMP_W'(quot_ff) * CMP_W'(MAP_WORD_BITS);
   assign rem_raw    = CMP_W'(page_ff) - quot_back;
   assign rem_over   = rem_raw >= CMP_W'(MAP_WORD_BITS);
   assign fix_word   = rem_over ? (quot_ff + CNT_W'(1)) : quot_ff;
   assign fix_bit    = rem_over ? (rem_raw - CMP_W'(MAP_WORD_BITS)) : rem_raw;
   assign chk_hit    = rd_data_i[bit_ff];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_ALLOC: state_in = ST_SCAN;
                  OP_FREE:  state_in = free_in_range ? ST_DIV : ST_DONE;
                  OP_INIT:  state_in = ST_SWEEP;
                  OP_NOP:   state_in = ST_DONE;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_SWEEP: begin
            if (sweep_last) begin
               state_in = respond_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (found || scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DIV:   state_in = ST_REM;
         ST_REM:   state_in = ST_CHECK;
         ST_CHECK: state_in = ST_DONE;
         ST_DONE: begin
            if (slot_free_i) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready_o = 1'b0;
      done_o      = 1'b0;
      rd_en_o     = 1'b0;
      rd_addr_o   = word_ff;
      wr_en_o     = 1'b0;
      wr_addr_o   = word_ff;
      wr_data_o   = sweep_data;
      unique case (state_ff)
         ST_IDLE:  req_ready_o = 1'b1;
         ST_SWEEP: wr_en_o = 1'b1;
         ST_SCAN: begin
            rd_en_o = issue;
            if (found) begin
               wr_en_o   = 1'b1;
               wr_addr_o = chk_word_ff;
               wr_data_o = rd_data_i | (MAP_WORD_BITS'(1) << found_pos);
            end
         end
         ST_DIV: ;
         ST_REM: begin
            rd_en_o   = 1'b1;
            rd_addr_o = WORD_W'(fix_word);
         end
         ST_CHECK: begin
            wr_en_o   = chk_hit;
            wr_data_o = rd_data_i & ~(MAP_WORD_BITS'(1) << bit_ff);
         end
         ST_DONE:  done_o = slot_free_i;
         default: ;
      endcase
   end

   always_comb begin
      status_in   = status_ff;
      paddr_in    = paddr_ff;
      page_in     = page_ff;
      used_in     = used_ff;
      fill_in     = fill_ff;
      quot_in     = quot_ff;
      word_in     = word_ff;
      base_in     = base_ff;
      bit_in      = bit_ff;
      chk_vld_in  = chk_vld_ff;
      chk_word_in = chk_word_ff;
      chk_base_in = chk_base_ff;
      respond_in  = respond_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               paddr_in   = '0;
               word_in    = '0;
               base_in    = '0;
               chk_vld_in = 1'b0;
               fill_in    = init_fill;
               respond_in = 1'b1;
               page_in    = CNT_W'(free_page_idx);
               unique case (req_op)
                  OP_ALLOC: status_in = STAT_NO_FREE;
                  OP_FREE:  status_in = free_in_range ? STAT_OK : STAT_IGNORED;
                  OP_INIT:  status_in = STAT_OK;
                  OP_NOP:   status_in = STAT_OK;
                  default:  status_in = STAT_OK;
               endcase
            end
         end
         ST_SWEEP: begin
            word_in = word_ff + WORD_W'(1);
            base_in = base_ff + BASE_W'(MAP_WORD_BITS);
            if (sweep_last) begin
               used_in = fill_ff;
            end
         end
         ST_SCAN: begin
            chk_vld_in  = issue;
            chk_word_in = word_ff;
            chk_base_in = base_ff;
            if (issue) begin
               word_in = word_ff + WORD_W'(1);
               base_in = base_ff + BASE_W'(MAP_WORD_BITS);
            end
            if (found) begin
               status_in = STAT_OK;
               used_in   = used_ff + CNT_W'(1);
               paddr_in  = to_paddr(CNT_W'(found_page));
            end
         end
         ST_DIV:   quot_in = CNT_W'(recip_prod >> RECIP_SHIFT);
         ST_REM: begin
            word_in = WORD_W'(fix_word);
            bit_in  = BIT_W'(fix_bit);
         end
         ST_CHECK: begin
            if (chk_hit) begin
               status_in = STAT_OK;
               used_in   = (used_ff != '0) ? (used_ff - CNT_W'(1)) : used_ff;
            end else begin
               status_in = STAT_IGNORED;
            end
         end
         ST_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_SWEEP;
         used_ff    <= '0;
         fill_ff    <= '0;
         word_ff    <= '0;
         base_ff    <= '0;
         chk_vld_ff <= 1'b0;
         respond_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         used_ff    <= used_in;
         fill_ff    <= fill_in;
         word_ff    <= word_in;
         base_ff    <= base_in;
         chk_vld_ff <= chk_vld_in;
         respond_ff <= respond_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      paddr_ff    <= paddr_in;
      page_ff     <= page_in;
      quot_ff     <= quot_in;
      bit_ff      <= bit_in;
      chk_word_ff <= chk_word_in;
      chk_base_ff <= chk_base_in;
   end

   assign result_o.status       = status_ff;
   assign result_o.page_address = paddr_ff;
   assign result_o.free_count   = (pages_i > used_ff) ? (pages_i - used_ff) : '0;
   assign result_o.used_count   = used_ff;

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      !(wr_en_o && rd_en_o && (wr_addr_o == rd_addr_o)))
      else $error("map read and write hit the same word");

   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(used_ff) <= 32'(MAX_PAGES))
      else $error("used count above the page limit");

   a_alloc_scans: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_op == OP_ALLOC)) |=> (state_ff == ST_SCAN))
      else $error("alloc did not start a scan");

   a_check_after_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> ($past(state_ff) == ST_REM))
      else $error("free check without its map read");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !slot_free_i) |=> (state_ff == ST_DONE))
      else $error("result dropped while the output slot was full");

endmodule

// ===== rtl/bitmap_page_allocator.sv =====
// channel  role    transaction carries
// -------  ------  ------------------------------------------------
// req      sink    op, free_address
// rsp      source  status, page_address, free_count, used_count
// csr      sink    index (0 page_count, 1 reserved_pages), data
//
// alloc scans the map words first-fit, pages = min(page_count, MAX_PAGES)
// free runs reciprocal multiply, correction with map read, then write back; out of range it skips them
// init writes one map word per cycle over all MAP_WORDS words; nop goes straight to the response
// after reset a clearing pass over all MAP_WORDS words runs before req is ready
// a full rsp register holds its result until taken; the next result then waits, req held low
module bitmap_page_allocator #(
   parameter int MAX_PAGES     = 4096,
   parameter int PAGE_SHIFT    = 12,
   parameter int MAP_WORD_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   bpa_req_if.sink   req_bus,
   bpa_rsp_if.source rsp_bus,
   bpa_csr_if.sink   csr_bus
);

   import bpa_pkg::*;

   localparam int MAP_WORDS = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

   logic [CNT_W-1:0]         page_count_ff, page_count_in;
   logic [CNT_W-1:0]         reserved_ff, reserved_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   result_type               rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]         pages;
   logic                     slot_free;
   logic                     done;
   result_type               result;
   logic                     rd_en;
   logic [WORD_W-1:0]        rd_addr;
   logic [MAP_WORD_BITS-1:0] rd_data;
   logic                     wr_en;
   logic [WORD_W-1:0]        wr_addr;
   logic [MAP_WORD_BITS-1:0] wr_data;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      page_count_in = page_count_ff;
      reserved_in   = reserved_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_PAGE_COUNT:     page_count_in = csr_bus.data;
            CSR_RESERVED_PAGES: reserved_in   = csr_bus.data;
            default: ;
         endcase
      end
   end

   assign pages = (32'(page_count_ff) > 32'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : page_count_ff;

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_count_ff <= PAGE_COUNT_RESET;
         reserved_ff   <= RESERVED_PAGES_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         page_count_ff <= page_count_in;
         reserved_ff   <= reserved_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_data_ff.status;
   assign rsp_bus.page_address = rsp_data_ff.page_address;
   assign rsp_bus.free_count   = rsp_data_ff.free_count;
   assign rsp_bus.used_count   = rsp_data_ff.used_count;

   bpa_map_ram #(
      .DEPTH (MAP_WORDS),
      .WIDTH (MAP_WORD_BITS)
   ) u_map_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   bpa_ctrl #(
      .MAX_PAGES     (MAX_PAGES),
      .PAGE_SHIFT    (PAGE_SHIFT),
      .MAP_WORD_BITS (MAP_WORD_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid_i (req_bus.valid),
      .req_ready_o (req_bus.ready),
      .req_op_i    (req_bus.op),
      .req_addr_i  (req_bus.free_address),
      .pages_i     (pages),
      .reserved_i  (reserved_ff),
      .slot_free_i (slot_free),
      .done_o      (done),
      .result_o    (result),
      .rd_en_o     (rd_en),
      .rd_addr_o   (rd_addr),
      .rd_data_i   (rd_data),
      .wr_en_o     (wr_en),
      .wr_addr_o   (wr_addr),
      .wr_data_o   (wr_data)
   );

endmodule
